// ----- sv/rcpf_pkg.sv -----
// rcpf_pkg: shared types, frame constants and byte-selection functions
// for the command packet framer; no dependencies
package rcpf_pkg;

  localparam int ByteW = 8;
  localparam int IdxW  = 4;   // frame index, longest frame is 15 bytes

  localparam logic [ByteW-1:0] SOF_BYTE   = 8'h8D;
  localparam logic [ByteW-1:0] EOF_BYTE   = 8'hD8;
  localparam logic [ByteW-1:0] FLAGS_BYTE = 8'h0A;
  localparam logic [ByteW-1:0] DEV_SYS    = 8'h13;
  localparam logic [ByteW-1:0] DEV_DRIVE  = 8'h16;
  localparam logic [ByteW-1:0] DEV_LED    = 8'h1A;
  localparam logic [ByteW-1:0] ID_WAKE    = 8'h0D;
  localparam logic [ByteW-1:0] ID_RST_HDG = 8'h06;
  localparam logic [ByteW-1:0] ID_DRIVE   = 8'h07;
  localparam logic [ByteW-1:0] ID_STAB    = 8'h0C;
  localparam logic [ByteW-1:0] ID_LEDS    = 8'h0E;
  localparam logic [ByteW-1:0] MASK_RGB   = 8'h7E;
  localparam logic [ByteW-1:0] MASK_AIM   = 8'h01;

  typedef enum logic [2:0] {
    CMD_WAKE          = 3'd0,
    CMD_RESET_HEADING = 3'd1,
    CMD_DRIVE         = 3'd2,
    CMD_SET_COLOUR    = 3'd3,
    CMD_AIMING_LED    = 3'd4,
    CMD_STABILIZATION = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REJECT,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic [7:0]  speed;
    logic [15:0] heading;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        enable;
  } req_t;

  // controller to datapath
  typedef struct packed {
    logic            load;
    logic            emit;
    logic            reject;
    logic [IdxW-1:0] idx;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_known;
    logic in_writable;
    logic slot_free;
    logic last_idx;
  } dp_sts_t;

  function automatic logic cmd_known(input logic [2:0] cmd);
    return (cmd <= 3'(CMD_STABILIZATION));
  endfunction

  function automatic logic [IdxW-1:0] pkt_len(input logic [2:0] cmd);
    logic [IdxW-1:0] len;
    case (cmd)
      CMD_WAKE:          len = 4'd7;
      CMD_RESET_HEADING: len = 4'd7;
      CMD_DRIVE:         len = 4'd11;
      CMD_SET_COLOUR:    len = 4'd15;
      CMD_AIMING_LED:    len = 4'd10;
      CMD_STABILIZATION: len = 4'd8;
      default:           len = 4'd7;
    endcase
    return len;
  endfunction

  // command-specific bytes from index 5 up to the checksum
  function automatic logic [ByteW-1:0] payload_byte(input logic [2:0] cmd,
                                                    input logic [IdxW-1:0] idx,
                                                    input req_t req);
    logic [ByteW-1:0] b;
    b = '0;
    case (cmd)
      CMD_DRIVE: begin
        case (idx)
          4'd5:    b = req.speed;
          4'd6:    b = req.heading[15:8];
          4'd7:    b = req.heading[7:0];
          default: b = '0;
        endcase
      end
      CMD_SET_COLOUR: begin
        case (idx)
          4'd6:    b = MASK_RGB;
          4'd7:    b = req.red;
          4'd8:    b = req.green;
          4'd9:    b = req.blue;
          4'd10:   b = req.red;
          4'd11:   b = req.green;
          4'd12:   b = req.blue;
          default: b = '0;
        endcase
      end
      CMD_AIMING_LED: begin
        case (idx)
          4'd6:    b = MASK_AIM;
          4'd7:    b = {ByteW{req.enable}};
          default: b = '0;
        endcase
      end
      CMD_STABILIZATION: begin
        if (idx == 4'd5) begin
          b = {7'd0, req.enable};
        end
      end
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [ByteW-1:0] frame_byte(input logic [2:0] cmd,
                                                  input logic [IdxW-1:0] idx,
                                                  input req_t req,
                                                  input logic [ByteW-1:0] seq,
                                                  input logic [ByteW-1:0] sum);
    logic [IdxW-1:0]  len;
    logic [ByteW-1:0] b;
    len = pkt_len(cmd);
    if (idx == 4'd0) begin
      b = SOF_BYTE;
    end else if (idx == IdxW'(len - 4'd1)) begin
      b = EOF_BYTE;
    end else if (idx == IdxW'(len - 4'd2)) begin
      b = ~sum;                       // 0xff minus the running sum
    end else if (idx == 4'd1) begin
      b = FLAGS_BYTE;
    end else if (idx == 4'd2) begin
      case (cmd)
        CMD_WAKE:       b = DEV_SYS;
        CMD_SET_COLOUR: b = DEV_LED;
        CMD_AIMING_LED: b = DEV_LED;
        default:        b = DEV_DRIVE;
      endcase
    end else if (idx == 4'd3) begin
      case (cmd)
        CMD_WAKE:          b = ID_WAKE;
        CMD_RESET_HEADING: b = ID_RST_HDG;
        CMD_DRIVE:         b = ID_DRIVE;
        CMD_STABILIZATION: b = ID_STAB;
        default:           b = ID_LEDS;
      endcase
    end else if (idx == 4'd4) begin
      b = seq;
    end else begin
      b = payload_byte(cmd, idx, req);
    end
    return b;
  endfunction

endpackage

// ----- sv/rcpf_ctrl.sv -----
// rcpf_ctrl: framer sequencer, walks the frame index and steers the datapath
// depends on rcpf_pkg
module rcpf_ctrl import rcpf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  state_t          state_r, state_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && sts.in_known) begin
          state_nxt = sts.in_writable ? ST_SEND : ST_REJECT;
        end
      end
      ST_REJECT: begin
        if (sts.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SEND: begin
        if (sts.slot_free && sts.last_idx) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    cmd.load   = (state_r == ST_IDLE) && in_tvalid;
    cmd.emit   = (state_r != ST_IDLE) && sts.slot_free;
    cmd.reject = (state_r == ST_REJECT);
    cmd.idx    = idx_r;
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.emit && !cmd.reject) begin
      idx_nxt = IdxW'(idx_r + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ----- sv/rcpf_datapath.sv -----
// rcpf_datapath: request capture, sequence counter, running checksum and
// output register; depends on rcpf_pkg
module rcpf_datapath import rcpf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [55:0]      in_tdata,
  input  logic [2:0]       in_tuser,
  input  ctl_cmd_t         cmd,
  output dp_sts_t          sts,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [ByteW-1:0] out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);

  req_t             req_r, req_nxt;
  logic [2:0]       cmd_r, cmd_nxt;
  logic [ByteW-1:0] sum_r, sum_nxt;
  logic [ByteW-1:0] seq_r, seq_nxt;
  logic             vld_r, vld_nxt;
  logic [ByteW-1:0] byte_r, byte_nxt;
  logic             last_r, last_nxt;
  logic             rej_r, rej_nxt;

  logic [IdxW-1:0]  len;
  logic [ByteW-1:0] cur_byte;
  logic             in_sum;

  assign len      = pkt_len(cmd_r);
  assign cur_byte = frame_byte(cmd_r, cmd.idx, req_r, seq_r, sum_r);
  assign in_sum   = (cmd.idx != 4'd0) && (cmd.idx <= IdxW'(len - 4'd3));

  always_comb begin
    sts.in_known    = cmd_known(in_tuser);
    sts.in_writable = in_tdata[49];
    sts.slot_free   = !vld_r || out_tready;
    sts.last_idx    = (cmd.idx == IdxW'(len - 4'd1));
  end

  always_comb begin
    req_nxt = req_r;
    cmd_nxt = cmd_r;
    sum_nxt = sum_r;
    seq_nxt = seq_r;
    if (cmd.load) begin
      req_nxt.speed   = in_tdata[7:0];
      req_nxt.heading = in_tdata[23:8];
      req_nxt.red     = in_tdata[31:24];
      req_nxt.green   = in_tdata[39:32];
      req_nxt.blue    = in_tdata[47:40];
      req_nxt.enable  = in_tdata[48];
      cmd_nxt         = in_tuser;
      sum_nxt         = '0;
    end else if (cmd.emit && !cmd.reject) begin
      if (in_sum) begin
        sum_nxt = ByteW'(sum_r + cur_byte);
      end
      if (sts.last_idx) begin
        seq_nxt = ByteW'(seq_r + 8'd1);
      end
    end
  end

  always_comb begin
    vld_nxt  = vld_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    rej_nxt  = rej_r;
    if (cmd.emit) begin
      vld_nxt  = 1'b1;
      byte_nxt = cmd.reject ? '0 : cur_byte;
      last_nxt = cmd.reject || sts.last_idx;
      rej_nxt  = cmd.reject;
    end else if (out_tready) begin
      vld_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      seq_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      seq_r <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    cmd_r  <= cmd_nxt;
    sum_r  <= sum_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    rej_r  <= rej_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;
  assign out_tuser  = rej_r;

endmodule

// ----- sv/robot_command_packet_framer.sv -----
// robot_command_packet_framer: top level, command request in, framed packet
// bytes out; depends on rcpf_pkg, rcpf_ctrl and rcpf_datapath
//
// usage
// - input channel in_*: one transaction is one command request; the command
//   code rides on in_tuser, the operands and the link-writable flag on in_tdata
// - output channel out_*: one transaction per packet byte, out_tlast marks the
//   closing 0xd8 byte, out_tuser marks a rejected request
// - a writable request yields its whole frame (7 to 15 bytes) with the running
//   sequence number in byte 4 and the sum-complement checksum before the end
// - a request while the link is not writable yields one zero byte with tlast
//   and tuser set; the sequence number does not move
// - command codes 6 and 7 are dropped with no output
// - after acceptance the sequencer enters ST_SEND and loads the first byte into
//   the output register once it has room; throughput: one byte per cycle from
//   the single output register while out_tready does not stall; the next
//   request is taken once the last byte is in the output register
// - a stall on out_tready freezes the byte walk; the output register holds
// - reset clears the sequence number and empties the output register
module robot_command_packet_framer import rcpf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // [7:0] speed, [23:8] heading, [31:24] red, [39:32] green, [47:40] blue,
  // [48] enable, [49] link_writable, [55:50] zero
  input  logic [55:0]      in_tdata,
  // [2:0] command
  input  logic [2:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // [7:0] packet_byte
  output logic [ByteW-1:0] out_tdata,
  // last_byte
  output logic             out_tlast,
  // [0] rejected
  output logic             out_tuser
);

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  // sequencer: walks the frame index while the output slot frees up
  rcpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (dp_sts),
    .cmd       (ctl_cmd)
  );

  // byte selection, checksum accumulation and output register
  rcpf_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (ctl_cmd),
    .sts        (dp_sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // a byte is only pushed into the output register when it has room
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.emit |-> dp_sts.slot_free)
    else $error("byte emitted into an occupied output register");

  // the first emitted byte of a frame is the start marker
  a_sof_first: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_cmd.emit && !ctl_cmd.reject && ctl_cmd.idx == '0) |=>
      (out_tvalid && out_tdata == SOF_BYTE && !out_tlast))
    else $error("frame does not open with the start marker");

  // a rejected request is a single zero byte that closes the transfer
  a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tlast && out_tdata == '0))
    else $error("rejected transaction is malformed");

  // no request is taken while a frame is still being walked
  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_cmd.emit && !ctl_cmd.reject && !dp_sts.last_idx) |=> !in_tready)
    else $error("request accepted in the middle of a frame");

endmodule
